// ===== design/bmmtk_pkg.sv =====
package bmmtk_pkg;

  localparam int DATA_W        = 32;
  localparam int WINDOW_DEF    = 100;
  localparam int LOW_COUNT_DEF = 5;

  // controls for one slot of the largest-interval chain
  typedef struct packed {
    logic en;
    logic clr;
  } cell_ctl_t;

  // block statistics carried alongside the mean division
  typedef struct packed {
    logic              fresh;
    logic [DATA_W-1:0] min;
    logic [DATA_W-1:0] max;
  } stat_t;

endpackage

// ===== design/bmmtk_cell.sv =====
module bmmtk_cell import bmmtk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] x,
  input  logic [DATA_W-1:0] up_val,
  input  logic              up_keep,
  output logic [DATA_W-1:0] val,
  output logic              keep
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  // hold when our entry is at least x; otherwise take x or the neighbour's shifted entry
  assign keep = (val_r >= x);
  assign val_nxt = keep ? val_r : (up_keep ? x : up_val);
  assign val = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (ctl.en) begin
      val_r <= ctl.clr ? '0 : val_nxt;
    end
  end

endmodule

// ===== design/bmmtk_div_stage.sv =====
module bmmtk_div_stage import bmmtk_pkg::*; #(
  parameter int LOW_COUNT = LOW_COUNT_DEF,
  parameter int SUM_W     = 35
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  num_in,
  input  stat_t             stat_in,
  output logic [DATA_W-1:0] quo_out,
  output stat_t             stat_out
);

  // floor(n / LOW_COUNT) == (n * RECIP) >> SHIFT for every n below 2^SUM_W
  localparam int SHIFT  = SUM_W + $clog2(LOW_COUNT);
  localparam int HALF_W = (SUM_W + 2) / 2;
  localparam int PROD_W = SUM_W + HALF_W;
  localparam int FULL_W = SUM_W + 2 * HALF_W;
  localparam logic [2*HALF_W-1:0] RECIP = (2 * HALF_W)'(
    ((64'd1 << SHIFT) + 64'(LOW_COUNT - 1)) / 64'(LOW_COUNT));
  localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
  localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];

  logic [PROD_W-1:0] lo_r;
  logic [PROD_W-1:0] hi_r;
  logic [FULL_W-1:0] full;
  logic [DATA_W-1:0] quo_r;
  stat_t             stat_a_r;
  stat_t             stat_b_r;

  // first step forms two half-width partial products, second step adds them
  assign full = {hi_r, {HALF_W{1'b0}}} + FULL_W'(lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r     <= PROD_W'(num_in) * PROD_W'(RECIP_LO);
      hi_r     <= PROD_W'(num_in) * PROD_W'(RECIP_HI);
      stat_a_r <= stat_in;
      quo_r    <= full[SHIFT +: DATA_W];
      stat_b_r <= stat_a_r;
    end
  end

  assign quo_out  = quo_r;
  assign stat_out = stat_b_r;

endmodule

// ===== design/block_min_max_top_k_mean_top.sv =====
// Pipeline: interval, fold into the cell chain, two reciprocal-multiply steps for the mean,
//   then the output register. Every stage advances together.
// Throughput: one item per cycle while the output register is empty or its result is taken.
// Reset (rst_n, synchronous, active low): previous reading, slot count, running and shown
//   statistics and the largest-interval list clear to zero, so the first item closes a block
//   with minimum 0. No result is valid after reset.
module block_min_max_top_k_mean_top import bmmtk_pkg::*; #(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int LOW_COUNT = LOW_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_clock_now,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_min_interval,
  output logic [DATA_W-1:0] out_max_interval,
  output logic [DATA_W-1:0] out_slow_mean,
  output logic              out_fresh
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = DATA_W + $clog2(LOW_COUNT);
  localparam int NSTG   = 4;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // Pipeline control: the whole chain advances when the output register is
  // empty or its transfer completes this cycle.
  logic            adv;
  logic            in_acc;
  logic [NSTG-1:0] vld_r;

  // Stage 0: interval from the previous reading, slot position.
  logic [DATA_W-1:0] prev_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [DATA_W-1:0] ival_r;
  logic              close_r;

  // Stage 1: running statistics and the chain of largest-interval cells.
  cell_ctl_t         cell_ctl;
  logic [DATA_W-1:0] list_val  [LOW_COUNT];
  logic              list_keep [LOW_COUNT];
  logic [DATA_W-1:0] min_r;
  logic [DATA_W-1:0] max_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DATA_W-1:0] min_nxt;
  logic [DATA_W-1:0] max_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  num1_r;
  stat_t             stat1_r;

  // Mean: sum of the largest intervals divided by LOW_COUNT.
  logic [DATA_W-1:0] quo_q;
  stat_t             stat_q;

  // Output register: the shown statistics double as the result payload.
  logic              out_valid_r;
  logic              out_fresh_r;
  logic [DATA_W-1:0] shown_min_r;
  logic [DATA_W-1:0] shown_max_r;
  logic [DATA_W-1:0] shown_slow_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: take the reading, form the modulo 2^32 interval, advance the slot.
  // A slot of zero marks the item that closes its block.
  // ---------------------------------------------------------------------------
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      slot_r <= '0;
    end else if (in_acc) begin
      prev_r <= in_clock_now;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ival_r  <= in_clock_now - prev_r;
      close_r <= (slot_r == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: fold the interval. Each cell holds one list entry in descending
  // order and compares it with the interval; its keep flag tells the next cell
  // whether to take the interval or shift the entry above down. Ties keep the
  // earlier copy in front. The running sum tracks the list: when the interval
  // enters, the tail entry drops out.
  // ---------------------------------------------------------------------------
  assign cell_ctl.en  = adv && vld_r[0];
  assign cell_ctl.clr = close_r;

  for (genvar g = 0; g < LOW_COUNT; g++) begin : g_cell
    if (g == 0) begin : g_head
      bmmtk_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cell_ctl),
        .x       (ival_r),
        .up_val  ('0),
        .up_keep (1'b1),
        .val     (list_val[g]),
        .keep    (list_keep[g])
      );
    end else begin : g_body
      bmmtk_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cell_ctl),
        .x       (ival_r),
        .up_val  (list_val[g-1]),
        .up_keep (list_keep[g-1]),
        .val     (list_val[g]),
        .keep    (list_keep[g])
      );
    end
  end

  assign min_nxt = (ival_r < min_r) ? ival_r : min_r;
  assign max_nxt = (ival_r > max_r) ? ival_r : max_r;
  assign sum_nxt = list_keep[LOW_COUNT-1] ? sum_r
                 : sum_r + SUM_W'(ival_r) - SUM_W'(list_val[LOW_COUNT-1]);

  // Restart the block after a close: min all ones, max and list zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
      sum_r <= '0;
    end else if (cell_ctl.en) begin
      if (close_r) begin
        min_r <= '1;
        max_r <= '0;
        sum_r <= '0;
      end else begin
        min_r <= min_nxt;
        max_r <= max_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1_r        <= sum_nxt;
      stat1_r.fresh <= close_r;
      stat1_r.min   <= min_nxt;
      stat1_r.max   <= max_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Mean: multiply by the reciprocal of LOW_COUNT over two stages, statistics
  // ride alongside.
  // ---------------------------------------------------------------------------
  bmmtk_div_stage #(
    .LOW_COUNT (LOW_COUNT),
    .SUM_W     (SUM_W)
  ) u_div (
    .clk      (clk),
    .en       (adv),
    .num_in   (num1_r),
    .stat_in  (stat1_r),
    .quo_out  (quo_q),
    .stat_out (stat_q)
  );

  // ---------------------------------------------------------------------------
  // Output register: latch new statistics when a closing item arrives, hold
  // them for every later item until the next close.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_fresh_r  <= 1'b0;
      shown_min_r  <= '0;
      shown_max_r  <= '0;
      shown_slow_r <= '0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG-1];
      if (vld_r[NSTG-1]) begin
        out_fresh_r <= stat_q.fresh;
        if (stat_q.fresh) begin
          shown_min_r  <= stat_q.min;
          shown_max_r  <= stat_q.max;
          shown_slow_r <= quo_q;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fresh        = out_fresh_r;
  assign out_min_interval = shown_min_r;
  assign out_max_interval = shown_max_r;
  assign out_slow_mean    = shown_slow_r;

`ifndef SYNTH
  a_min_le_max : assert property (@(posedge clk) disable iff (!rst_n)
    shown_min_r <= shown_max_r)
    else $error("shown minimum exceeds shown maximum");

  a_mean_le_max : assert property (@(posedge clk) disable iff (!rst_n)
    shown_slow_r <= shown_max_r)
    else $error("mean of largest intervals exceeds maximum");

  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_LAST)
    else $error("slot position beyond block length");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(sum_r))
    else $error("pipeline moved while stalled");
`endif

endmodule
